FILE: src/stereo_ring_modulator_assert.svh
// assertion macros used by the ring modulator port checker
`ifndef STEREO_RING_MODULATOR_ASSERT_SVH
`define STEREO_RING_MODULATOR_ASSERT_SVH

// implication checked while reset is low
`define SRM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stereo ring modulator check failed");

// next-cycle implication, also checked across reset
`define SRM_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("stereo ring modulator check failed");

`endif

FILE: src/srm_pkg.sv
// constants, register codes and sine table generator for the ring modulator
package srm_pkg;

  localparam int SINE_W      = 16;
  localparam int SINE_MAG_W  = 15;
  localparam int SINE_FRAC   = 15;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int STEP_W      = 32;

  localparam logic [63:0] SINE_PEAK   = 64'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic {
    REG_PHASE_STEP = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_index_t;

  // round(32767 * sin(pi/2 * k / 2^addr_bits)), taylor series in q2.30
  function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned k,
                                                       input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (sum > term) ? sum - term : 64'd0;
    r    = (sum * SINE_PEAK + (64'd1 << 29)) >> 30;
    if (r > SINE_PEAK) begin
      r = SINE_PEAK;
    end
    return r[SINE_MAG_W-1:0];
  endfunction

endpackage

FILE: src/srm_in_if.sv
// input channel carrying one stereo frame per item
interface srm_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

FILE: src/srm_out_if.sv
// output channel carrying one modulated stereo frame per item
interface srm_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

FILE: src/stereo_ring_modulator.sv
// stereo ring modulator: phase accumulator, quarter-wave sine table, two multipliers
// three register stages: input/phase decode, registered table read, product register
// path: an accepted frame passes the input, table read and product registers in order; an output stall holds it longer
// throughput: one stereo frame per cycle while the output is ready, each stage refills as soon as it empties
// reset: clears phase, phase step and all stage valid bits; sine table is constant logic
module stereo_ring_modulator
  import srm_pkg::*;
#(
  parameter int SAMPLE_BITS     = 24,
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  srm_in_if.sink                samples,
  srm_out_if.source             products,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TAB_N  = 1 << TABLE_ADDR_BITS;
  localparam int PROD_W = SAMPLE_BITS + SINE_W;

  logic [SINE_MAG_W-1:0] sine_rom [TAB_N+1];

  for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, TABLE_ADDR_BITS);
  end

  logic [STEP_W-1:0]     phase_step;
  logic [PHASE_BITS-1:0] phase;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_left;
  logic signed [SAMPLE_BITS-1:0] s1_right;
  logic [TABLE_ADDR_BITS:0]      s1_addr;
  logic                          s1_neg;

  logic                          s2_valid;
  logic signed [SAMPLE_BITS-1:0] s2_left;
  logic signed [SAMPLE_BITS-1:0] s2_right;
  logic signed [SINE_W-1:0]      s2_sine;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  logic                          out_free;
  logic                          s2_free;
  logic                          s1_free;
  logic                          take;
  logic                          cfg_write;
  logic [1:0]                    quad;
  logic [TABLE_ADDR_BITS-1:0]    idx;
  logic [TABLE_ADDR_BITS:0]      addr_next;
  logic signed [SINE_W-1:0]      sine_mag;
  logic signed [PROD_W-1:0]      prod_left;
  logic signed [PROD_W-1:0]      prod_right;

  // each stage takes a new item when empty or when its item moves on
  assign out_free = !out_valid || products.ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign take     = samples.valid && s1_free;

  assign samples.ready      = s1_free;
  assign products.valid     = out_valid;
  assign products.left_out  = out_left;
  assign products.right_out = out_right;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (reg_index_t'(paddr[2]) == REG_PHASE_STEP);
  assign prdata    = (reg_index_t'(paddr[2]) == REG_PHASE_STEP) ? phase_step : '0;

  // quadrant folding onto the quarter-wave table
  assign quad      = phase[PHASE_BITS-1 -: 2];
  assign idx       = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign addr_next = quad[0] ? ((TABLE_ADDR_BITS+1)'(TAB_N) - {1'b0, idx}) : {1'b0, idx};

  assign sine_mag   = {1'b0, sine_rom[s1_addr]};
  assign prod_left  = s2_left * s2_sine;
  assign prod_right = s2_right * s2_sine;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      phase      <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        phase_step <= pwdata;
      end
      if (take) begin
        phase <= phase + PHASE_BITS'(phase_step);
      end
      if (s1_free) begin
        s1_valid <= samples.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_left  <= samples.left_in;
      s1_right <= samples.right_in;
      s1_addr  <= addr_next;
      s1_neg   <= quad[1];
    end
    if (s2_free && s1_valid) begin
      s2_left  <= s1_left;
      s2_right <= s1_right;
      s2_sine  <= s1_neg ? -sine_mag : sine_mag;
    end
    // dropping the low fraction bits of a two's complement product floors it
    if (out_free && s2_valid) begin
      out_left  <= prod_left[SINE_FRAC +: SAMPLE_BITS];
      out_right <= prod_right[SINE_FRAC +: SAMPLE_BITS];
    end
  end

endmodule

FILE: src/srm_checker.sv
// port-level checks for the stereo ring modulator and their bind
`include "stereo_ring_modulator_assert.svh"

module srm_checker
  import srm_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] left_out,
  input logic [SAMPLE_BITS-1:0] right_out,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic                   pready,
  input logic [APB_ADDR_W-1:0]  paddr,
  input logic [APB_DATA_W-1:0]  pwdata,
  input logic [APB_DATA_W-1:0]  prdata
);

  logic step_write;
  logic step_read;

  assign step_write = psel && penable && pwrite && pready &&
                      (reg_index_t'(paddr[2]) == REG_PHASE_STEP);
  assign step_read  = psel && !pwrite && (reg_index_t'(paddr[2]) == REG_PHASE_STEP);

  // no item survives reset in the pipeline
  `SRM_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid)

  // a stalled result stays offered
  `SRM_ASSERT_NEXT(a_out_hold, clk, out_valid && !out_ready && !rst, out_valid || rst)

  // a stalled result keeps its payload
  `SRM_ASSERT_IMPLY(a_out_stable, clk, rst,
    $past(out_valid && !out_ready) && !$past(rst),
    $stable(left_out) && $stable(right_out))

  // the step register reads back what was just written
  `SRM_ASSERT_IMPLY(a_step_readback, clk, rst,
    step_read && $past(step_write) && !$past(rst),
    prdata == $past(pwdata))

endmodule

bind stereo_ring_modulator srm_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_srm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (products.valid),
  .out_ready (products.ready),
  .left_out  (products.left_out),
  .right_out (products.right_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

FILE: tb/stereo_ring_modulator_checker.sv
// checker for the ring modulator: predicts each modulated frame and compares it with the output
module stereo_ring_modulator_checker
  import srm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  srm_in_if                     in_ch,
  srm_out_if                    out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatch_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = 24;
  localparam int PHASE_W    = 32;
  localparam int TABLE_BITS = 10;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  logic [SINE_MAG_W-1:0] quarter_rom [0:TABLE_SIZE];
  logic [PHASE_W-1:0]    carrier_acc;
  logic [STEP_W-1:0]     tuning_word;
  frame_t                frame_expect_q[$];

  // round(peak * sin(pi/2 * k / table size)) by a q2.30 taylor series
  function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] r;
    int n;
    x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc > term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    r = (acc * SINE_PEAK + (64'd1 << 29)) >> 30;
    if (r > SINE_PEAK) begin
      r = SINE_PEAK;
    end
    return r[SINE_MAG_W-1:0];
  endfunction

  // quadrant folding of the quarter table, lower phase bits dropped
  function automatic logic signed [SINE_MAG_W+1:0] carrier_value(input logic [PHASE_W-1:0] ph);
    logic [1:0]                  quad;
    logic [TABLE_BITS-1:0]       idx;
    int unsigned                 k;
    logic signed [SINE_MAG_W+1:0] mag;
    quad = ph[PHASE_W-1 -: 2];
    idx  = ph[PHASE_W-3 -: TABLE_BITS];
    k    = quad[0] ? (TABLE_SIZE - int'(idx)) : int'(idx);
    mag  = $signed({2'b00, quarter_rom[k]});
    return quad[1] ? -mag : mag;
  endfunction

  // product floored back to the sample format
  function automatic logic signed [SAMPLE_W-1:0] scale_sample(
    input logic signed [SAMPLE_W-1:0]   s,
    input logic signed [SINE_MAG_W+1:0] c
  );
    logic signed [SAMPLE_W+SINE_MAG_W+1:0] p;
    p = s * c;
    return p[SAMPLE_W+SINE_FRAC-1:SINE_FRAC];
  endfunction

  initial begin
    for (int k = 0; k <= TABLE_SIZE; k++) begin
      quarter_rom[k] = quarter_sine(k);
    end
  end

  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    logic signed [SINE_MAG_W+1:0] c;
    if (rst) begin
      carrier_acc = '0;
      tuning_word = '0;
      frame_expect_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.left  = out_ch.left_out;
        got.right = out_ch.right_out;
        if (frame_expect_q.size() == 0) begin
          $error("output item with no frame expected: left_out %0d right_out %0d",
                 got.left, got.right);
          mismatch_count++;
        end else begin
          want = frame_expect_q.pop_front();
          if (got.left !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, got.left);
            mismatch_count++;
          end
          if (got.right !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, got.right);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        c          = carrier_value(carrier_acc);
        want.left  = scale_sample(in_ch.left_in, c);
        want.right = scale_sample(in_ch.right_in, c);
        frame_expect_q.push_back(want);
        carrier_acc = carrier_acc + tuning_word;
      end
      // writes to the unused index leave the step alone
      if (psel && penable && pwrite && pready &&
          reg_index_t'(paddr[APB_ADDR_W-1:2]) == REG_PHASE_STEP) begin
        tuning_word = pwdata[STEP_W-1:0];
      end
    end
    pending = frame_expect_q.size();
  end

endmodule

FILE: tb/stereo_ring_modulator_tb.sv
// top of the ring modulator testbench: clock, reset, frame and register stimulus, verdict
module stereo_ring_modulator_tb;
  import srm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W       = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 84;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG1 = '1;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_ZERO = '0;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatch_count;
  int                    pending;
  int                    idle_cycles;
  bit                    in_burst;
  bit                    out_burst;

  srm_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  srm_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

  stereo_ring_modulator dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (in_ch),
    .products (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  stereo_ring_modulator_checker mod_check (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_NEG1;
      3: return SAMPLE_ZERO;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return STEP_W'($urandom());
      1: return STEP_W'($urandom_range(1, 1 << 22));
      2: return STEP_W'(0) - STEP_W'($urandom_range(1, 1 << 22));
      3: return {2'($urandom_range(0, 3)), 30'd0};
      4: return '1;
      default: return STEP_W'($urandom_range(0, 1 << 16)) << 14;
    endcase
  endfunction

  // one frame: optional gap with valid low, then hold until accepted
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
    int gap;
    if ($urandom_range(0, 15) == 0) begin
      in_burst = !in_burst;
    end
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic reg_write(input reg_index_t idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // lower valid and wait until every predicted frame has come out
  task automatic drain_frames();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // output side: per item stall with ready low, sometimes long stretches without
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    out_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        out_burst = !out_burst;
      end
      stall = out_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.left_in  <= '0;
    in_ch.right_in <= '0;
    in_burst = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step still at reset: first frames sit at phase zero, sine zero
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    drain_frames();

    // quarter turn per frame: every quadrant edge, full peak, then wrap to zero
    reg_write(REG_PHASE_STEP, {2'b01, 30'd0});
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(SAMPLE_NEG1, SAMPLE_ZERO);
    send_frame(SAMPLE_ZERO, SAMPLE_NEG1);
    drain_frames();

    // write to the unused index must not touch the step
    reg_write(REG_UNUSED, $urandom());
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    drain_frames();

    // largest step: phase runs backwards through the wrap
    reg_write(REG_PHASE_STEP, '1);
    send_frame(SAMPLE_MAX, SAMPLE_NEG1);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(SAMPLE_NEG1, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    drain_frames();

    // one table entry per frame
    reg_write(REG_PHASE_STEP, 32'h0010_0000);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_NEG1, SAMPLE_NEG1);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(SAMPLE_ZERO, SAMPLE_MAX);
    drain_frames();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        reg_write(REG_UNUSED, $urandom());
      end
      reg_write(REG_PHASE_STEP, pick_step());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_frame(pick_sample(), pick_sample());
      end
      drain_frames();
    end

    // wait past the pipeline depth for stray outputs
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
